@@ hw/rtl/lr64c_pkg.sv @@
// Shared types, constants and alphabet functions of the LSB-first radix-64 codec.
package lr64c_pkg;

   // Emitted-count width: default and port width.
   localparam int CountWidthDefault = 32;
   localparam int CountPortWidth    = 32;

   // Result queue: deep enough for one item's worst case on top of one waiting entry.
   localparam int MaxResults    = 3;
   localparam int FifoDepth     = 4;
   localparam int FifoPtrWidth  = $clog2(FifoDepth);
   localparam int FifoFillWidth = $clog2(FifoDepth + 1);
   localparam int ResCountWidth = $clog2(MaxResults + 1);

   // Widths of the stream payloads.
   localparam int ReqDataWidth = 8;
   localparam int RspDataWidth = 48;

   // Result kinds.
   localparam logic KindData   = 1'b0;
   localparam logic KindStatus = 1'b1;

   // Direction register codes.
   localparam logic DirDecode = 1'b0;
   localparam logic DirEncode = 1'b1;

   // Register index of the direction register.
   localparam logic RegDirection = 1'b0;

   // Alphabet boundaries in value space.
   localparam logic [5:0] ValUpperStart = 6'h0A;
   localparam logic [5:0] ValLowerStart = 6'h24;
   localparam logic [5:0] ValPlus       = 6'h3E;
   localparam logic [5:0] ValSlash      = 6'h3F;
   localparam logic [7:0] InvalidCode   = 8'hFF;

   // ASCII characters of the alphabet.
   localparam logic [7:0] CharDigit0 = 8'h30;
   localparam logic [7:0] CharDigit9 = 8'h39;
   localparam logic [7:0] CharUpperA = 8'h41;
   localparam logic [7:0] CharUpperZ = 8'h5A;
   localparam logic [7:0] CharLowerA = 8'h61;
   localparam logic [7:0] CharLowerZ = 8'h7A;
   localparam logic [7:0] CharPlus   = 8'h2B;
   localparam logic [7:0] CharSlash  = 8'h2F;

   // One queued result, apart from its count.
   typedef struct packed {
      logic       kind;
      logic [7:0] out_byte;
      logic       halted;
      logic       run_last;
   } rsp_entry_type;

   // Maps a 6-bit value to its character.
   function automatic logic [7:0] value_to_char(input logic [5:0] v);
      logic [7:0] c;
      priority if (v < ValUpperStart) begin
         c = CharDigit0 + {2'b00, v};
      end else if (v < ValLowerStart) begin
         c = CharUpperA + {2'b00, v - ValUpperStart};
      end else if (v < ValPlus) begin
         c = CharLowerA + {2'b00, v - ValLowerStart};
      end else if (v == ValPlus) begin
         c = CharPlus;
      end else begin
         c = CharSlash;
      end
      return c;
   endfunction

   // Maps a character to its value, or InvalidCode outside the alphabet.
   function automatic logic [7:0] char_to_value(input logic [7:0] c);
      logic [7:0] v;
      priority if (c >= CharDigit0 && c <= CharDigit9) begin
         v = c - CharDigit0;
      end else if (c >= CharUpperA && c <= CharUpperZ) begin
         v = c - CharUpperA + {2'b00, ValUpperStart};
      end else if (c >= CharLowerA && c <= CharLowerZ) begin
         v = c - CharLowerA + {2'b00, ValLowerStart};
      end else if (c == CharPlus) begin
         v = {2'b00, ValPlus};
      end else if (c == CharSlash) begin
         v = {2'b00, ValSlash};
      end else begin
         v = InvalidCode;
      end
      return v;
   endfunction

endpackage

@@ hw/rtl/lsb_first_radix64_codec_core.sv @@
// Top level of the LSB-first radix-64 codec: input register, codec step and result queue.
// A transaction accepted on req waits in the input register until the queue can take its worst case;
// it is then written to the result queue, and its first result is offered on rsp from the queue head.
// Throughput: set by the one-result-per-cycle output port while rsp_tready is high; an item gives
// up to three results, and a new item moves on while at most one earlier result waits in the queue.
// Reset clears the direction (decode), the message state, the input register and the queue.
module lsb_first_radix64_codec_core #(
   parameter int COUNT_WIDTH = lr64c_pkg::CountWidthDefault
) (
   input  logic        clock,
   input  logic        reset,
   // Input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [lr64c_pkg::ReqDataWidth-1:0] req_tdata,  // [7:0] in_byte
   input  logic        req_tlast,                         // last_of_message
   // Result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [lr64c_pkg::RspDataWidth-1:0] rsp_tdata,  // [7:0] out_byte,
                                                          // [39:8] written_count,
                                                          // [40] halted, [47:41] zero
   output logic        rsp_tuser,                         // kind
   output logic        rsp_tlast,                         // run_last
   // Configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int PtrW  = lr64c_pkg::FifoPtrWidth;
   localparam int FillW = lr64c_pkg::FifoFillWidth;
   localparam int NW    = lr64c_pkg::ResCountWidth;
   localparam int MaxR  = lr64c_pkg::MaxResults;

   // Configuration and message state. The accumulator never holds more than six bits
   // between transactions, so six bits of storage and a three-bit count suffice.
   logic                   dir_ff;
   logic [5:0]             acc_ff, acc_in;
   logic [2:0]             held_ff, held_in;
   logic                   stopped_ff, stopped_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in;

   // Input register.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // Result queue.
   lr64c_pkg::rsp_entry_type fifo_ff [lr64c_pkg::FifoDepth];
   logic [COUNT_WIDTH-1:0]   fifo_cnt_ff [lr64c_pkg::FifoDepth];
   logic [PtrW-1:0]          wr_ptr_ff, rd_ptr_ff;
   logic [FillW-1:0]         fill_ff, fill_in;

   // Step outputs.
   lr64c_pkg::rsp_entry_type res [MaxR];
   logic [COUNT_WIDTH-1:0]   res_cnt [MaxR];
   logic [NW-1:0]            n_res;

   logic csr_write, dir_write, consume, pop;
   logic [FillW-1:0] push_n;

   // APB: always ready; a write to any address other than the direction register is dropped.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign dir_write  = csr_write && (csr_paddr[2] == lr64c_pkg::RegDirection);
   assign csr_prdata = (csr_paddr[2] == lr64c_pkg::RegDirection) ? 32'(dir_ff) : 32'd0;

   // The held transaction moves on only when the queue can take its worst case, which keeps
   // the ready path free of rsp_tready.
   assign consume    = in_valid_ff &&
                       (fill_ff <= FillW'(lr64c_pkg::FifoDepth - MaxR));
   assign req_tready = !in_valid_ff || consume;

   assign rsp_tvalid = (fill_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;

   // Codec step: one transaction against the message state.
   always_comb begin
      logic [11:0]        enc_bits, dec_bits;
      logic [3:0]         enc_held, dec_held;
      logic [7:0]         cval;
      logic [7:0]         data_bytes [MaxR];
      logic [NW-1:0]      n_data;
      logic [COUNT_WIDTH:0] sum;
      logic [COUNT_WIDTH-1:0] total_sat;

      acc_in     = acc_ff;
      held_in    = held_ff;
      stopped_in = stopped_ff;
      n_data     = '0;
      for (int k = 0; k < MaxR; k++) begin
         data_bytes[k] = '0;
      end

      // New group ORed in above the bits already held.
      enc_bits = ({4'b0000, in_byte_ff} << held_ff) | {6'b000000, acc_ff};
      enc_held = {1'b0, held_ff} + 4'd8;
      cval     = lr64c_pkg::char_to_value(in_byte_ff);
      dec_bits = ({6'b000000, cval[5:0]} << held_ff) | {6'b000000, acc_ff};
      dec_held = {1'b0, held_ff} + 4'd6;

      if (dir_ff == lr64c_pkg::DirEncode) begin
         // Eight, ten or twelve bits are held now: always one character, a second one
         // when twelve are held or when the residue is flushed at the end of the message.
         data_bytes[0] = lr64c_pkg::value_to_char(enc_bits[5:0]);
         data_bytes[1] = lr64c_pkg::value_to_char(enc_bits[11:6]);
         if (enc_held == 4'd12) begin
            n_data  = NW'(2);
            acc_in  = '0;
            held_in = '0;
         end else begin
            acc_in  = enc_bits[11:6];
            held_in = 3'(enc_held - 4'd6);
            n_data  = in_last_ff ? NW'(2) : NW'(1);
         end
      end else if (!stopped_ff) begin
         if (cval == lr64c_pkg::InvalidCode) begin
            stopped_in = 1'b1;
         end else if (dec_held >= 4'd8) begin
            data_bytes[0] = dec_bits[7:0];
            n_data        = NW'(1);
            acc_in        = 6'(dec_bits[11:8]);
            held_in       = 3'(dec_held - 4'd8);
         end else begin
            acc_in  = dec_bits[5:0];
            held_in = 3'(dec_held);
         end
      end

      // Saturating message count.
      sum       = {1'b0, total_ff} + (COUNT_WIDTH+1)'(n_data);
      total_sat = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
      total_in  = total_sat;

      // Data results first, then the status result on the last transaction of a message.
      for (int k = 0; k < MaxR; k++) begin
         res[k]     = '0;
         res_cnt[k] = '0;
         if (NW'(k) < n_data) begin
            res[k].kind     = lr64c_pkg::KindData;
            res[k].out_byte = data_bytes[k];
         end else if (NW'(k) == n_data && in_last_ff) begin
            res[k].kind   = lr64c_pkg::KindStatus;
            res[k].halted = stopped_in;
            res_cnt[k]    = total_sat;
         end
      end
      n_res = n_data + NW'(in_last_ff);
      for (int k = 0; k < MaxR; k++) begin
         if (NW'(k + 1) == n_res) begin
            res[k].run_last = 1'b1;
         end
      end

      if (in_last_ff) begin
         acc_in     = '0;
         held_in    = '0;
         stopped_in = 1'b0;
         total_in   = '0;
      end
   end

   assign push_n  = consume ? FillW'(n_res) : '0;
   assign fill_in = fill_ff + push_n - FillW'(pop);

   // Input register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata[7:0];
         in_last_ff <= req_tlast;
      end
   end

   // Direction and message state. Any direction write abandons the message in progress.
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff     <= lr64c_pkg::DirDecode;
         acc_ff     <= '0;
         held_ff    <= '0;
         stopped_ff <= 1'b0;
         total_ff   <= '0;
      end else if (dir_write) begin
         dir_ff     <= csr_pwdata[0];
         acc_ff     <= '0;
         held_ff    <= '0;
         stopped_ff <= 1'b0;
         total_ff   <= '0;
      end else if (consume) begin
         acc_ff     <= acc_in;
         held_ff    <= held_in;
         stopped_ff <= stopped_in;
         total_ff   <= total_in;
      end
   end

   // Queue pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PtrW'(push_n);
         rd_ptr_ff <= rd_ptr_ff + PtrW'(pop);
         fill_ff   <= fill_in;
      end
   end

   // Queue entries: up to three consecutive slots written at once.
   always_ff @(posedge clock) begin
      for (int k = 0; k < MaxR; k++) begin
         if (consume && (NW'(k) < n_res)) begin
            fifo_ff[wr_ptr_ff + PtrW'(k)]     <= res[k];
            fifo_cnt_ff[wr_ptr_ff + PtrW'(k)] <= res_cnt[k];
         end
      end
   end

   // Head of the queue drives the result stream.
   assign rsp_tuser = fifo_ff[rd_ptr_ff].kind;
   assign rsp_tlast = fifo_ff[rd_ptr_ff].run_last;
   assign rsp_tdata = {7'b0000000,
                       fifo_ff[rd_ptr_ff].halted,
                       lr64c_pkg::CountPortWidth'(fifo_cnt_ff[rd_ptr_ff]),
                       fifo_ff[rd_ptr_ff].out_byte};

   // The queue never holds more than its depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FillW'(lr64c_pkg::FifoDepth))
      else $error("result queue overfilled");

   // A status result always closes the run of results of its transaction.
   a_status_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == lr64c_pkg::KindStatus) |-> rsp_tlast)
      else $error("status result without run_last");

   // Data results carry no count.
   a_data_no_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == lr64c_pkg::KindData) |-> fifo_cnt_ff[rd_ptr_ff] == '0)
      else $error("data result with non-zero count");

   // A held transaction that cannot move on stays put.
   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !consume |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff))
      else $error("held transaction lost or changed");

endmodule

@@ tb/tb_lsb_first_radix64_codec_core.sv @@
// Self-checking testbench of the LSB-first radix-64 codec core, driven and checked on its streams.
module tb_lsb_first_radix64_codec_core;

   // Timing of the run. The clock period is two half periods of four time units.
   localparam int ClockHalf      = 4;
   localparam int ResetCycles    = 11;
   // An accepted item passes the core's input register before the result queue; DrainCycles quiet
   // cycles are ample for an item that produces nothing to leave the pipeline.
   localparam int DrainCycles    = 8;
   localparam int LongHoldCycles = 300;
   localparam int CycleLimit     = 400000;
   localparam int PhaseCount     = 8;
   localparam int PhaseItems     = 55;

   // Register map: the direction register is index 0, so byte address 0. Address 4 decodes to
   // index 1, which holds no register and must be ignored.
   localparam logic [2:0]  AddrDirection = 3'd0;
   localparam logic [2:0]  AddrSpare     = 3'd4;
   localparam logic [31:0] CountMax      = 32'hFFFF_FFFF;

   // Alphabet anchors used by the predictor.
   localparam logic [7:0] AsciiZero   = "0";
   localparam logic [7:0] AsciiNine   = "9";
   localparam logic [7:0] AsciiUpperA = "A";
   localparam logic [7:0] AsciiUpperZ = "Z";
   localparam logic [7:0] AsciiLowerA = "a";
   localparam logic [7:0] AsciiLowerZ = "z";
   localparam logic [7:0] AsciiPlus   = "+";
   localparam logic [7:0] AsciiSlash  = "/";
   localparam int         NotInAlphabet = -1;

   // One input transaction as the driver offers it.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       last;
   } codec_item_type;

   // One result transaction as the monitor expects to see it.
   typedef struct packed {
      logic        kind;
      logic [7:0]  out_byte;
      logic [31:0] count;
      logic        halted;
      logic        run_last;
   } codec_result_type;

   logic                               clock       = 1'b0;
   logic                               reset       = 1'b1;
   logic                               req_tvalid  = 1'b0;
   logic                               req_tready;
   logic [lr64c_pkg::ReqDataWidth-1:0] req_tdata   = '0;   // [7:0] in_byte
   logic                               req_tlast   = 1'b0; // last_of_message
   logic                               rsp_tvalid;
   logic                               rsp_tready  = 1'b0;
   logic [lr64c_pkg::RspDataWidth-1:0] rsp_tdata;          // [7:0] out_byte,
                                                           // [39:8] written_count,
                                                           // [40] halted, [47:41] zero
   logic                               rsp_tuser;          // kind
   logic                               rsp_tlast;          // run_last
   logic                               csr_psel    = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite  = 1'b0;
   logic [2:0]                         csr_paddr   = '0;
   logic [31:0]                        csr_pwdata  = '0;
   logic [31:0]                        csr_prdata;
   logic                               csr_pready;

   // Items waiting to be offered, and results predicted but not yet seen.
   codec_item_type   pending_items[$];
   codec_result_type expected_results[$];

   // The predictor's own copy of the configuration and of the message state.
   logic        codec_dir     = lr64c_pkg::DirDecode;
   logic [15:0] acc_bits      = '0;
   int          acc_count     = 0;
   logic        halt_seen     = 1'b0;
   logic [31:0] written_total = '0;

   int fail_count     = 0;
   int accepted_items = 0;
   int cycle_count    = 0;
   int send_gap       = 0;
   int stall_left     = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;
   // Set for the closing phase, in which neither side idles.
   bit calm           = 1'b0;

   lsb_first_radix64_codec_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #ClockHalf clock = 1'b1;
      #ClockHalf clock = 1'b0;
   end

   // Value 0..63 to its character: digits, then upper case, then lower case, then '+' and '/'.
   function automatic logic [7:0] sixbit_to_ascii(input logic [5:0] v);
      if (v < 6'd10) begin
         return AsciiZero + {2'b00, v};
      end else if (v < 6'd36) begin
         return AsciiUpperA + {2'b00, v - 6'd10};
      end else if (v < 6'd62) begin
         return AsciiLowerA + {2'b00, v - 6'd36};
      end else if (v == 6'd62) begin
         return AsciiPlus;
      end else begin
         return AsciiSlash;
      end
   endfunction

   // Character to its value, or NotInAlphabet for anything else.
   function automatic int ascii_to_sixbit(input logic [7:0] c);
      if (c >= AsciiZero && c <= AsciiNine) begin
         return int'(c - AsciiZero);
      end else if (c >= AsciiUpperA && c <= AsciiUpperZ) begin
         return int'(c - AsciiUpperA) + 10;
      end else if (c >= AsciiLowerA && c <= AsciiLowerZ) begin
         return int'(c - AsciiLowerA) + 36;
      end else if (c == AsciiPlus) begin
         return 62;
      end else if (c == AsciiSlash) begin
         return 63;
      end else begin
         return NotInAlphabet;
      end
   endfunction

   function automatic codec_result_type data_result(input logic [7:0] b);
      return '{kind: lr64c_pkg::KindData, out_byte: b, count: 32'd0, halted: 1'b0,
               run_last: 1'b0};
   endfunction

   // The emitted count sticks at its maximum rather than wrapping.
   function automatic void bump_total();
      if (written_total != CountMax) written_total++;
   endfunction

   function automatic void clear_message();
      acc_bits      = '0;
      acc_count     = 0;
      halt_seen     = 1'b0;
      written_total = '0;
   endfunction

   // Works out the results of one accepted input transaction and queues them in order.
   task automatic predict_item(input logic [7:0] in_byte, input logic last);
      codec_result_type produced[3];
      int               n;
      int               v;
      n = 0;
      if (codec_dir == lr64c_pkg::DirEncode) begin
         // New bits go in above those already held; characters leave from the bottom.
         acc_bits  = acc_bits | ({8'h00, in_byte} << acc_count);
         acc_count = acc_count + 8;
         while (acc_count >= 6 && n < 2) begin
            produced[n] = data_result(sixbit_to_ascii(acc_bits[5:0]));
            n++;
            bump_total();
            acc_bits  = acc_bits >> 6;
            acc_count = acc_count - 6;
         end
         // The end of a message flushes the remainder as one zero-padded character.
         if (last && acc_count > 0 && n < 2) begin
            produced[n] = data_result(sixbit_to_ascii(acc_bits[5:0]));
            n++;
            bump_total();
            acc_bits  = '0;
            acc_count = 0;
         end
      end else if (!halt_seen) begin
         v = ascii_to_sixbit(in_byte);
         if (v == NotInAlphabet) begin
            // An invalid character silences the rest of the message.
            halt_seen = 1'b1;
         end else begin
            acc_bits  = acc_bits | (16'(v) << acc_count);
            acc_count = acc_count + 6;
            if (acc_count >= 8) begin
               produced[n] = data_result(acc_bits[7:0]);
               n++;
               bump_total();
               acc_bits  = acc_bits >> 8;
               acc_count = acc_count - 8;
            end
         end
      end
      // Leftover decode bits are simply dropped when the message is cleared.
      if (last) begin
         produced[n] = '{kind: lr64c_pkg::KindStatus, out_byte: 8'h00, count: written_total,
                         halted: halt_seen, run_last: 1'b0};
         n++;
         clear_message();
      end
      for (int i = 0; i < n; i++) begin
         produced[i].run_last = (i == n - 1);
         expected_results.push_back(produced[i]);
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 'h%0h, actual 'h%0h", name, want, got);
         fail_count++;
      end
   endtask

   // Driver: offers the pending items in order, holding each until it is taken, with bursts of
   // idle cycles between transactions while the run is not calm. Only one nonblocking
   // assignment to req_tvalid is made per edge.
   always @(posedge clock) begin : drive_requests
      codec_item_type next_item;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_item(req_tdata, req_tlast);
            accepted_items++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(1, 18) - 1;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               next_item = pending_items.pop_front();
               req_tdata  <= next_item.in_byte;
               req_tlast  <= next_item.last;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks every accepted result transaction against the oldest expectation, and
   // paces rsp_tready. Once, while plenty of items are still waiting, it holds off for a long
   // stretch so that the result queue fills and the core stalls its input.
   always @(posedge clock) begin : watch_results
      codec_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("result transaction with no expectation waiting: tdata 'h%0h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               compare_field("kind", want.kind, rsp_tuser);
               compare_field("out_byte", want.out_byte, rsp_tdata[7:0]);
               compare_field("written_count", want.count, rsp_tdata[39:8]);
               compare_field("halted", want.halted, rsp_tdata[40]);
               compare_field("run_last", want.run_last, rsp_tlast);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && accepted_items > 60 && pending_items.size() > 30) begin
            hold_done = 1'b1;
            hold_left = LongHoldCycles - 1;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // One register transaction: a setup phase, then the access phase until pready is seen.
   task automatic csr_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic check_direction();
      logic [31:0] rdata;
      csr_access(1'b0, AddrDirection, 32'd0, rdata);
      compare_field("direction", {31'd0, codec_dir}, rdata);
   endtask

   // Any write to the direction register, even of the same value, abandons the message in hand.
   // A write to the spare address changes nothing.
   task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
      logic [31:0] rdata;
      csr_access(1'b1, addr, value, rdata);
      if (addr == AddrDirection) begin
         codec_dir = value[0];
         clear_message();
      end
      check_direction();
   endtask

   task automatic queue_item(input logic [7:0] in_byte, input logic last);
      pending_items.push_back('{in_byte: in_byte, last: last});
   endtask

   // Random messages of geometric length. Decoding sees mostly alphabet characters with the
   // odd arbitrary byte; the final message of a phase is sometimes left open.
   task automatic queue_random(input int count);
      codec_item_type it;
      for (int i = 0; i < count; i++) begin
         if (codec_dir == lr64c_pkg::DirEncode || $urandom_range(0, 15) == 0) begin
            it.in_byte = 8'($urandom_range(0, 255));
         end else begin
            it.in_byte = sixbit_to_ascii(6'($urandom_range(0, 63)));
         end
         it.last = ($urandom_range(0, 6) == 0) || (i == count - 1 && $urandom_range(0, 3) != 0);
         pending_items.push_back(it);
      end
   endtask

   // Waits at falling edges, when every update of the rising edge has settled, until nothing
   // is offered or expected, and then lets the pipeline drain.
   task automatic wait_until_idle();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_results.size() != 0);
      repeat (DrainCycles) @(negedge clock);
   endtask

   initial begin : run_sequence
      logic [31:0] wvalue;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      check_direction();

      // Decoding after reset: every boundary of the alphabet in one message, six bytes out.
      queue_item("0", 1'b0);
      queue_item("9", 1'b0);
      queue_item("A", 1'b0);
      queue_item("Z", 1'b0);
      queue_item("a", 1'b0);
      queue_item("z", 1'b0);
      queue_item("+", 1'b0);
      queue_item("/", 1'b1);
      // An invalid character halts the message; the last item still gives the status.
      queue_item("A", 1'b0);
      queue_item(8'h00, 1'b0);
      queue_item("B", 1'b0);
      queue_item(8'hFF, 1'b1);
      // A lone character leaves six bits that are dropped.
      queue_item("z", 1'b1);
      // Bits left pending across a write to the spare address must survive it.
      queue_item("Q", 1'b0);
      wait_until_idle();
      write_register(AddrSpare, 32'hFFFF_FFFF);
      queue_item("w", 1'b1);
      wait_until_idle();

      // Encoding: extreme bytes, a lone byte that needs a flush, and a rewrite of the same
      // direction in the middle of a message.
      write_register(AddrDirection, {31'd0, lr64c_pkg::DirEncode});
      queue_item(8'h00, 1'b0);
      queue_item(8'hFF, 1'b0);
      queue_item(8'h80, 1'b0);
      queue_item(8'h01, 1'b1);
      queue_item(8'hFF, 1'b1);
      queue_item(8'h5A, 1'b0);
      wait_until_idle();
      write_register(AddrDirection, 32'hFFFF_FFFF);
      queue_item(8'hC3, 1'b1);
      queue_item(8'h7E, 1'b0);
      queue_item(8'h81, 1'b1);
      wait_until_idle();

      // Random phases, each under a fresh direction setting; the last one runs without idling.
      for (int phase = 0; phase < PhaseCount; phase++) begin
         if (phase == PhaseCount - 1) calm = 1'b1;
         if ($urandom_range(0, 2) == 0) write_register(AddrSpare, $urandom());
         wvalue = $urandom();
         wvalue[0] = (phase < 2) ? ((phase % 2) == 1) : ($urandom_range(0, 1) == 1);
         write_register(AddrDirection, wvalue);
         queue_random(PhaseItems);
         wait_until_idle();
      end

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
